// ===== rtl/core/apvsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apvsc_pkg
// Shared types and constants of the peak/valley step counter.
// ----------------------------------------------------------------------------
package apvsc_pkg;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int LEVEL_SQ_WIDTH  = 2 * CFG_DATA_WIDTH;
    localparam int OUT_WIDTH       = 32;
    localparam int QUEUE_DEPTH     = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PEAK_LEVEL   = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VALLEY_LEVEL = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_INTERVAL = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STRIDE       = 8'd3;

    // Reset values: 12.5 m/s^2 and 10.2 m/s^2 in 1/128 m/s^2, 600 ms, 0.7 m
    localparam logic [CFG_DATA_WIDTH-1:0] PEAK_LEVEL_RST   = 16'd1600;
    localparam logic [CFG_DATA_WIDTH-1:0] VALLEY_LEVEL_RST = 16'd1306;
    localparam logic [CFG_DATA_WIDTH-1:0] MIN_INTERVAL_RST = 16'd600;
    localparam logic [CFG_DATA_WIDTH-1:0] STRIDE_RST       = 16'd700;

    localparam logic [LEVEL_SQ_WIDTH-1:0] PEAK_SQ_RST =
        LEVEL_SQ_WIDTH'(PEAK_LEVEL_RST) * LEVEL_SQ_WIDTH'(PEAK_LEVEL_RST);
    localparam logic [LEVEL_SQ_WIDTH-1:0] VALLEY_SQ_RST =
        LEVEL_SQ_WIDTH'(VALLEY_LEVEL_RST) * LEVEL_SQ_WIDTH'(VALLEY_LEVEL_RST);

    // Live configuration, levels already squared
    typedef struct packed {
        logic [LEVEL_SQ_WIDTH-1:0] peak_sq;
        logic [LEVEL_SQ_WIDTH-1:0] valley_sq;
        logic [CFG_DATA_WIDTH-1:0] min_interval_ms;
        logic [CFG_DATA_WIDTH-1:0] stride_mm;
    } apvsc_cfg_t;

    // Classification of one sample, passed from front to back
    typedef struct packed {
        logic below_peak;
        logic below_valley;
    } apvsc_class_t;

    localparam int CLASS_WIDTH = $bits(apvsc_class_t);

endpackage
`default_nettype wire

// ===== rtl/core/apvsc_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apvsc_regs
// Configuration registers; peak and valley levels are stored squared.
// ----------------------------------------------------------------------------
module apvsc_regs
    import apvsc_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output apvsc_cfg_t                      cfg
);

    apvsc_cfg_t                cfg_reg;
    logic [LEVEL_SQ_WIDTH-1:0] data_sq;

    assign data_sq   = {{CFG_DATA_WIDTH{1'b0}}, cfg_data} * {{CFG_DATA_WIDTH{1'b0}}, cfg_data};
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak_sq         <= PEAK_SQ_RST;
            cfg_reg.valley_sq       <= VALLEY_SQ_RST;
            cfg_reg.min_interval_ms <= MIN_INTERVAL_RST;
            cfg_reg.stride_mm       <= STRIDE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PEAK_LEVEL:   cfg_reg.peak_sq         <= data_sq;
                REG_VALLEY_LEVEL: cfg_reg.valley_sq       <= data_sq;
                REG_MIN_INTERVAL: cfg_reg.min_interval_ms <= cfg_data;
                REG_STRIDE:       cfg_reg.stride_mm       <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/apvsc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apvsc_front
// Two-stage classifier: square each axis, then sum and compare with levels.
// ----------------------------------------------------------------------------
module apvsc_front
    import apvsc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TIME_WIDTH   = 48
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z,
    input  wire logic [TIME_WIDTH-1:0]          time_ms,
    input  wire logic [LEVEL_SQ_WIDTH-1:0]      peak_sq,
    input  wire logic [LEVEL_SQ_WIDTH-1:0]      valley_sq,
    output logic                                sq_valid,
    output logic                                item_valid,
    output apvsc_class_t                        item_class,
    output logic [TIME_WIDTH-1:0]               item_time
);

    localparam int SQ_W  = 2 * SAMPLE_WIDTH;
    localparam int MAG_W = SQ_W + 2;
    localparam int CMP_W = (MAG_W > LEVEL_SQ_WIDTH) ? MAG_W : LEVEL_SQ_WIDTH;

    logic signed [SQ_W-1:0] prod_x;
    logic signed [SQ_W-1:0] prod_y;
    logic signed [SQ_W-1:0] prod_z;
    logic [SQ_W-1:0]        sq_x_reg;
    logic [SQ_W-1:0]        sq_y_reg;
    logic [SQ_W-1:0]        sq_z_reg;
    logic [TIME_WIDTH-1:0]  sq_time_reg;
    logic                   sq_valid_reg;
    logic [CMP_W-1:0]       mag;
    apvsc_class_t           class_next;
    apvsc_class_t           class_reg;
    logic [TIME_WIDTH-1:0]  time_reg;
    logic                   valid_reg;

    // A square is never negative and fits the unsigned product width
    assign prod_x = SQ_W'(accel_x) * SQ_W'(accel_x);
    assign prod_y = SQ_W'(accel_y) * SQ_W'(accel_y);
    assign prod_z = SQ_W'(accel_z) * SQ_W'(accel_z);

    assign mag = CMP_W'(sq_x_reg) + CMP_W'(sq_y_reg) + CMP_W'(sq_z_reg);

    always_comb
    begin
        class_next.below_peak   = mag < CMP_W'(peak_sq);
        class_next.below_valley = mag < CMP_W'(valley_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            sq_valid_reg <= accept;
            valid_reg    <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_x_reg    <= SQ_W'(unsigned'(prod_x));
            sq_y_reg    <= SQ_W'(unsigned'(prod_y));
            sq_z_reg    <= SQ_W'(unsigned'(prod_z));
            sq_time_reg <= time_ms;
        end
        if (sq_valid_reg)
        begin
            class_reg <= class_next;
            time_reg  <= sq_time_reg;
        end
    end

    assign sq_valid   = sq_valid_reg;
    assign item_valid = valid_reg;
    assign item_class = class_reg;
    assign item_time  = time_reg;

endmodule
`default_nettype wire

// ===== rtl/core/apvsc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apvsc_queue
// Small show-ahead queue between the classifier and the step tracker.
// ----------------------------------------------------------------------------
module apvsc_queue
#(
    parameter int WIDTH = 50,
    parameter int DEPTH = 4
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic [WIDTH-1:0]                pop_data,
    output logic                            not_empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule
`default_nettype wire

// ===== rtl/core/apvsc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apvsc_back
// Step tracker: arm/disarm logic, interval check, saturating totals, result
// register.
// ----------------------------------------------------------------------------
module apvsc_back
    import apvsc_pkg::*;
#(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    input  wire apvsc_class_t              item_class,
    input  wire logic [TIME_WIDTH-1:0]     item_time,
    input  wire logic [CFG_DATA_WIDTH-1:0] min_interval_ms,
    input  wire logic [CFG_DATA_WIDTH-1:0] stride_mm,
    output logic                           pop,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           step_seen,
    output logic [OUT_WIDTH-1:0]           total_steps,
    output logic [OUT_WIDTH-1:0]           total_distance_mm
);

    localparam int SUM_W = COUNT_WIDTH + 1;

    logic                   prev_below_reg;
    logic                   armed_reg;
    logic                   armed_next;
    logic [TIME_WIDTH-1:0]  last_step_reg;
    logic [COUNT_WIDTH-1:0] steps_reg;
    logic [COUNT_WIDTH-1:0] steps_next;
    logic [COUNT_WIDTH-1:0] dist_reg;
    logic [COUNT_WIDTH-1:0] dist_next;
    logic                   step_seen_reg;
    logic                   out_valid_reg;
    logic [TIME_WIDTH-1:0]  gap;
    logic                   step;
    logic [SUM_W-1:0]       steps_sum;
    logic [SUM_W-1:0]       dist_sum;

    assign pop = item_valid && (!out_valid_reg || out_ready);

    // Interval wraps modulo the timestamp width
    assign gap  = item_time - last_step_reg;
    assign step = armed_reg && prev_below_reg && !item_class.below_peak
                  && (gap > TIME_WIDTH'(min_interval_ms));

    assign steps_sum = SUM_W'(steps_reg) + SUM_W'(1);
    assign dist_sum  = SUM_W'(dist_reg) + SUM_W'(stride_mm);

    always_comb
    begin
        steps_next = steps_reg;
        dist_next  = dist_reg;
        if (step)
        begin
            steps_next = steps_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                : steps_sum[COUNT_WIDTH-1:0];
            dist_next  = dist_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                               : dist_sum[COUNT_WIDTH-1:0];
        end
    end

    // Disarm on a step; re-arm below the valley only while disarmed
    always_comb
    begin
        if (armed_reg)
        begin
            armed_next = !step;
        end
        else
        begin
            armed_next = item_class.below_valley;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_below_reg <= 1'b1;
            armed_reg      <= 1'b1;
            last_step_reg  <= '0;
            steps_reg      <= '0;
            dist_reg       <= '0;
            step_seen_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (pop)
        begin
            prev_below_reg <= item_class.below_peak;
            armed_reg      <= armed_next;
            if (step)
            begin
                last_step_reg <= item_time;
            end
            steps_reg     <= steps_next;
            dist_reg      <= dist_next;
            step_seen_reg <= step;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Totals change only when a new result loads, so they drive the port directly
    assign out_valid         = out_valid_reg;
    assign step_seen         = step_seen_reg;
    assign total_steps       = OUT_WIDTH'(steps_reg);
    assign total_distance_mm = OUT_WIDTH'(dist_reg);

endmodule
`default_nettype wire

// ===== rtl/core/accel_peak_valley_step_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// accel_peak_valley_step_counter
// Peak/valley pedometer on three-axis acceleration samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) moves one word per sample: accel_x,
//   accel_y, accel_z in 1/128 m/s^2 and the millisecond timestamp time_ms.
//   Output channel (out_valid/out_ready) returns exactly one word per sample:
//   step_seen and the saturating totals total_steps and total_distance_mm.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   peak level, valley level, minimum interval and stride; write it only
//   while no sample is in flight. cfg_ready is always high.
// Timing:
//   An accepted sample passes two classifier stages (squares, then sum and
//   level compare), one queue write and one tracker update before its result
//   is valid. Throughput is one sample per cycle while out_ready stays high.
// Stalls:
//   The result register frees as soon as it is taken, so the tracker drains
//   the queue at full rate. When out_ready stays low, the queue fills and
//   in_ready drops once queue plus classifier stages hold four samples.
// Reset:
//   rst_n clears the queue and the stages, loads the default levels, and arms
//   the detector with zero totals and the last step time at zero.
// ----------------------------------------------------------------------------
module accel_peak_valley_step_counter
    import apvsc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TIME_WIDTH   = 48,
    parameter int COUNT_WIDTH  = 32
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z,
    input  wire logic [TIME_WIDTH-1:0]          time_ms,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                step_seen,
    output logic [OUT_WIDTH-1:0]                total_steps,
    output logic [OUT_WIDTH-1:0]                total_distance_mm,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]      cfg_data
);

    localparam int Q_WIDTH = CLASS_WIDTH + TIME_WIDTH;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W   = CNT_W + 1;

    apvsc_cfg_t            cfg;
    logic                  accept;
    logic                  sq_valid;
    logic                  front_valid;
    apvsc_class_t          front_class;
    logic [TIME_WIDTH-1:0] front_time;
    logic [Q_WIDTH-1:0]    q_data;
    logic                  q_not_empty;
    logic [CNT_W-1:0]      q_count;
    logic                  q_pop;
    apvsc_class_t          back_class;
    logic [TIME_WIDTH-1:0] back_time;
    logic [OCC_W-1:0]      occupancy;

    // Count samples in the classifier stages and the queue; the front never
    // stalls, so hold off new words only when the queue could not take them all
    assign occupancy = OCC_W'(q_count) + OCC_W'(sq_valid) + OCC_W'(front_valid);
    assign in_ready  = occupancy < OCC_W'(QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;

    apvsc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    apvsc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .time_ms    (time_ms),
        .peak_sq    (cfg.peak_sq),
        .valley_sq  (cfg.valley_sq),
        .sq_valid   (sq_valid),
        .item_valid (front_valid),
        .item_class (front_class),
        .item_time  (front_time)
    );

    apvsc_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data ({front_class, front_time}),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign back_class = apvsc_class_t'(q_data[Q_WIDTH-1:TIME_WIDTH]);
    assign back_time  = q_data[TIME_WIDTH-1:0];

    apvsc_back #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (q_not_empty),
        .item_class        (back_class),
        .item_time         (back_time),
        .min_interval_ms   (cfg.min_interval_ms),
        .stride_mm         (cfg.stride_mm),
        .pop               (q_pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .step_seen         (step_seen),
        .total_steps       (total_steps),
        .total_distance_mm (total_distance_mm)
    );

endmodule
`default_nettype wire

// ===== bench/accel_peak_valley_step_counter_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// accel_peak_valley_step_counter_tb
// Self-checking bench for the peak/valley step counter. A queue of samples
// feeds a bursty driver. A local tracker predicts step_seen and both
// saturating totals for every accepted sample. A monitor checks each result
// word in order while the receiver stalls on its own pattern. The run walks
// through several register settings, a long receiver hold-off, and a
// full-stride stepping pass.
// ----------------------------------------------------------------------------
module accel_peak_valley_step_counter_tb
    import apvsc_pkg::*;
();

    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 48;
    localparam int CYCLE_CAP  = 1_500_000;
    localparam int HOLD_LEN   = 300;
    localparam int STRIDE_STEPS = 8;

    // Index with no register behind it; the block must ignore the write
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NONE = 8'hA5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
        logic [TIME_W-1:0]          t;
    } sample_t;

    typedef struct packed {
        logic                 step_seen;
        logic [OUT_WIDTH-1:0] steps;
        logic [OUT_WIDTH-1:0] dist_mm;
    } totals_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE_STALL,
        RX_HALF,
        RX_PERIODIC
    } rx_pattern_e;

    // ------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [SAMPLE_W-1:0]  accel_x = '0;
    logic signed [SAMPLE_W-1:0]  accel_y = '0;
    logic signed [SAMPLE_W-1:0]  accel_z = '0;
    logic [TIME_W-1:0]           time_ms = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        step_seen;
    logic [OUT_WIDTH-1:0]        total_steps;
    logic [OUT_WIDTH-1:0]        total_distance_mm;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data = '0;

    accel_peak_valley_step_counter dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .accel_x           (accel_x),
        .accel_y           (accel_y),
        .accel_z           (accel_z),
        .time_ms           (time_ms),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .step_seen         (step_seen),
        .total_steps       (total_steps),
        .total_distance_mm (total_distance_mm),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracker copy: live registers and detector state, as after reset
    // ------------------------------------------------------------------
    logic [CFG_DATA_WIDTH-1:0] peak_level      = PEAK_LEVEL_RST;
    logic [CFG_DATA_WIDTH-1:0] valley_level    = VALLEY_LEVEL_RST;
    logic [CFG_DATA_WIDTH-1:0] min_interval_ms = MIN_INTERVAL_RST;
    logic [CFG_DATA_WIDTH-1:0] stride_mm       = STRIDE_RST;

    logic                 trk_prev_below = 1'b1;
    logic                 trk_armed      = 1'b1;
    logic [TIME_W-1:0]    trk_last_ms    = '0;
    logic [OUT_WIDTH-1:0] trk_steps      = '0;
    logic [OUT_WIDTH-1:0] trk_dist       = '0;

    sample_t samples_pending[$];
    totals_t totals_due[$];
    int      err_count = 0;
    int      cycle_count = 0;

    // Sender shaping; the sequencer sets gap_max on falling edges
    int          gap_max = 3;
    int          burst_left = 0;
    int          gap_left = 0;
    sample_t     cur_sample;

    // Receiver shaping; the sequencer bumps hold_reqs to ask for a hold-off
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          pat_left = 0;
    rx_pattern_e pat_mode = RX_OPEN;

    // Stimulus timestamp walk
    logic [TIME_W-1:0] now_ms = '0;

    function automatic longint unsigned axis_sq(logic signed [SAMPLE_W-1:0] a);
        longint w;
        w = a;
        return longint'(w * w);
    endfunction

    // Advance the detector by one sample and return the result word it owes
    function automatic totals_t track_step(sample_t s);
        longint unsigned   mag_sq;
        longint unsigned   peak_sq;
        longint unsigned   valley_sq;
        logic              below;
        logic [TIME_W-1:0] gap;
        logic [OUT_WIDTH:0] sum;
        totals_t           r;
        mag_sq    = axis_sq(s.x) + axis_sq(s.y) + axis_sq(s.z);
        peak_sq   = longint'(peak_level) * longint'(peak_level);
        valley_sq = longint'(valley_level) * longint'(valley_level);
        below     = (mag_sq < peak_sq);
        r.step_seen = 1'b0;
        if (trk_armed)
        begin
            // Interval wraps at the timestamp width
            gap = s.t - trk_last_ms;
            if (trk_prev_below && !below && gap > TIME_W'(min_interval_ms))
            begin
                r.step_seen = 1'b1;
                if (trk_steps != '1)
                    trk_steps = trk_steps + 1'b1;
                sum = {1'b0, trk_dist} + (OUT_WIDTH+1)'(stride_mm);
                trk_dist = sum[OUT_WIDTH] ? '1 : sum[OUT_WIDTH-1:0];
                trk_last_ms = s.t;
                trk_armed = 1'b0;
            end
        end
        else if (mag_sq < valley_sq)
        begin
            trk_armed = 1'b1;
        end
        trk_prev_below = below;
        r.steps   = trk_steps;
        r.dist_mm = trk_dist;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: hold the word until taken, then pull the next one from the
    // pending queue in bursts with random gaps between them
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Predict at acceptance, so results line up in input order
            if (in_valid && in_ready)
                totals_due.push_back(track_step(cur_sample));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (samples_pending.size() != 0)
                begin
                    cur_sample = samples_pending.pop_front();
                    accel_x  <= cur_sample.x;
                    accel_y  <= cur_sample.y;
                    accel_z  <= cur_sample.z;
                    time_ms  <= cur_sample.t;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else
                    begin
                        // End of burst: pick the next burst and the gap ahead of it
                        burst_left = $urandom_range(0, 24);
                        gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, switched after a random run length, and a
    // long hold-off on request so the block backs up into its input
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_mode = rx_pattern_e'($urandom_range(0, 3));
                pat_left = $urandom_range(16, 200);
            end
            pat_left = pat_left - 1;
            case (pat_mode)
                RX_OPEN:         out_ready <= 1'b1;
                RX_SPARSE_STALL: out_ready <= ($urandom_range(0, 3) != 0);
                RX_HALF:         out_ready <= 1'($urandom_range(0, 1));
                default:         out_ready <= (pat_left % 3 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every taken result word with the oldest prediction
    // ------------------------------------------------------------------
    task automatic note_mismatch(string field, longint unsigned want,
                                 longint unsigned got);
        err_count = err_count + 1;
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        totals_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (totals_due.size() == 0)
            begin
                note_mismatch("result word with none pending, total_steps", 0,
                              total_steps);
            end
            else
            begin
                want = totals_due.pop_front();
                if (step_seen !== want.step_seen)
                    note_mismatch("step_seen", want.step_seen, step_seen);
                if (total_steps !== want.steps)
                    note_mismatch("total_steps", want.steps, total_steps);
                if (total_distance_mm !== want.dist_mm)
                    note_mismatch("total_distance_mm", want.dist_mm, total_distance_mm);
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------

    // Write one register; call on a rising edge, return on a rising edge
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                             logic [CFG_DATA_WIDTH-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PEAK_LEVEL:   peak_level = val;
            REG_VALLEY_LEVEL: valley_level = val;
            REG_MIN_INTERVAL: min_interval_ms = val;
            REG_STRIDE:       stride_mm = val;
            default:          ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_levels(int peak, int valley, int min_ms, int stride);
        write_reg(REG_PEAK_LEVEL, CFG_DATA_WIDTH'(peak));
        write_reg(REG_VALLEY_LEVEL, CFG_DATA_WIDTH'(valley));
        write_reg(REG_MIN_INTERVAL, CFG_DATA_WIDTH'(min_ms));
        write_reg(REG_STRIDE, CFG_DATA_WIDTH'(stride));
    endtask

    // Wait until every sample is taken and every result word has come back,
    // then let the pipeline settle
    task automatic drain();
        do
            @(posedge clk);
        while (samples_pending.size() != 0 || in_valid || totals_due.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic push_sample(int x, int y, int z, logic [TIME_W-1:0] t);
        sample_t s;
        s.x = SAMPLE_W'(x);
        s.y = SAMPLE_W'(y);
        s.z = SAMPLE_W'(z);
        s.t = t;
        samples_pending.push_back(s);
    endtask

    // Walking-like sample: mostly near the peak or the valley level with a
    // forward-moving clock, some full-range noise and clock jumps
    function automatic sample_t make_sample();
        sample_t s;
        int      kind;
        int      mag;
        int      axis;
        logic signed [SAMPLE_W-1:0] v [3];
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3)
            now_ms = TIME_W'({$urandom, $urandom});
        else
            now_ms = now_ms + TIME_W'($urandom_range(0, 350));
        s.t = now_ms;
        if (kind < 15)
        begin
            s.x = SAMPLE_W'($urandom);
            s.y = SAMPLE_W'($urandom);
            s.z = SAMPLE_W'($urandom);
        end
        else
        begin
            if (kind < 55)
                mag = int'(peak_level) - 12 + int'($urandom_range(0, 60));
            else
                mag = int'(valley_level) + 12 - int'($urandom_range(0, 60));
            if (mag < 0)
                mag = 0;
            if (mag > 32767)
                mag = 32767;
            for (int i = 0; i < 3; i++)
                v[i] = SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
            axis = $urandom_range(0, 2);
            v[axis] = $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
            s.x = v[0];
            s.y = v[1];
            s.z = v[2];
        end
        return s;
    endfunction

    // Queue a batch of random samples, optionally park the receiver, drain
    task automatic run_random(int count, int gaps, bit hold);
        @(negedge clk);
        gap_max = gaps;
        for (int i = 0; i < count; i++)
            samples_pending.push_back(make_sample());
        if (hold)
            hold_reqs = hold_reqs + 1;
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass on the reset levels (1600 / 1306 / 600 ms)
        @(negedge clk);
        gap_max = 3;
        // First sample may step; all axes at the negative extreme
        push_sample(-32768, -32768, -32768, 601);
        push_sample(32767, 32767, 32767, 602);
        push_sample(0, 0, 0, 700);
        // Gap equal to the minimum does not count, one more does
        push_sample(1600, 0, 0, 1201);
        push_sample(0, 0, 0, 1202);
        push_sample(0, 1600, 0, 1202);
        // Valley boundary: just below the peak does not re-arm, just below the valley does
        push_sample(0, 0, 1599, 1300);
        push_sample(0, 0, 1305, 1301);
        // Magnitude straddles the peak by a hair on two axes
        push_sample(1131, 1131, 0, 5000);
        push_sample(1132, 1131, 0, 5001);
        // Clock runs backwards: interval wraps to a large value
        push_sample(0, 0, 0, 100);
        push_sample(-1600, 0, 0, 50);
        // Clock at its top, then wraps to zero with an interval of one
        push_sample(0, 0, 0, '1);
        push_sample(0, 0, -1600, '1);
        push_sample(0, 0, 0, 0);
        push_sample(1600, 0, 0, 0);
        push_sample(0, 0, 0, 700);
        push_sample(1600, 0, 0, 700);
        // Exactly at the valley while disarmed: stays disarmed
        push_sample(0, 0, 1306, 800);
        push_sample(-1305, 0, 0, 801);
        now_ms = 801;
        drain();

        // Reset levels with random walking, receiver parked for a while
        run_random(150, 2, 1'b1);

        // All registers at their top
        set_levels(65535, 65535, 65535, 65535);
        run_random(100, 4, 1'b0);

        // Smallest peak, zero valley (never re-arms), zero interval and stride
        set_levels(1, 0, 0, 0);
        write_reg(REG_NONE, CFG_DATA_WIDTH'($urandom));
        run_random(80, 5, 1'b0);

        // Zero peak: every sample sits at or above it
        set_levels(0, 500, 100, 1234);
        run_random(80, 0, 1'b0);

        // Valley above peak: a stepping sample may also sit below the valley
        set_levels(800, 3000, 50, 65535);
        run_random(150, 1, 1'b1);

        // Random settings around typical walking levels
        for (int p = 0; p < 5; p++)
        begin
            set_levels($urandom_range(900, 2600), $urandom_range(0, 2600),
                       $urandom_range(0, 900), $urandom_range(0, 65535));
            run_random(200, $urandom_range(0, 6), (p == 2));
        end

        // Full stride, one step every two samples, back to back
        set_levels(1600, 1306, 0, 65535);
        @(negedge clk);
        gap_max = 0;
        for (int i = 0; i < STRIDE_STEPS; i++)
        begin
            now_ms = now_ms + 1'b1;
            push_sample(0, 0, 0, now_ms);
            now_ms = now_ms + 1'b1;
            push_sample(0, 1600, 0, now_ms);
        end
        drain();

        // Back to the reset levels
        set_levels(PEAK_LEVEL_RST, VALLEY_LEVEL_RST, MIN_INTERVAL_RST, STRIDE_RST);
        run_random(100, 3, 1'b0);

        if (err_count == 0 && totals_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/apvsc_pkg.sv
rtl/core/apvsc_regs.sv
rtl/core/apvsc_front.sv
rtl/core/apvsc_queue.sv
rtl/core/apvsc_back.sv
rtl/core/accel_peak_valley_step_counter.sv
bench/accel_peak_valley_step_counter_tb.sv
